### sv/erz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erz_pkg
// Shared constants and the CORDIC arctangent table for the ZYX rotator.
// ----------------------------------------------------------------------------
package erz_pkg;

  localparam int POINT_COUNT    = 3;
  localparam int COORD_BITS     = 24;
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int TURN_BITS      = 32;
  localparam int CORDIC_STEPS   = 30;
  localparam int CORDIC_FRAC    = 30;
  localparam int CORDIC_XW      = 34;
  localparam int CORDIC_ZW      = 33;
  localparam int CORDIC_GAIN_INV = 652032874;

  localparam int TRIG_LAT = CORDIC_STEPS + 2;
  localparam int MAT_LAT  = 3;
  localparam int LANE_LAT = 2;
  localparam int PIPE_LAT = TRIG_LAT + MAT_LAT + LANE_LAT;

  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      5'd24:   v = 30'd41;
      5'd25:   v = 30'd20;
      5'd26:   v = 30'd10;
      5'd27:   v = 30'd5;
      5'd28:   v = 30'd3;
      5'd29:   v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/euler_zyx_rotate_three_vectors_top.sv
`timescale 1ns / 1ps
// Pipeline: 1 angle register, 30 CORDIC stages, 1 trig rounding stage, 3 matrix
//   stages and 2 lane stages lie between input beat and result beat.
// Throughput: one beat per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, active low; clears only the pipeline valid bits.
// ----------------------------------------------------------------------------
// euler_zyx_rotate_three_vectors_top
// Rotates three points by the ZYX Euler matrix built from roll, pitch, yaw.
// ----------------------------------------------------------------------------
module euler_zyx_rotate_three_vectors_top #(
  parameter int COORD_BITS     = erz_pkg::COORD_BITS,
  parameter int ANGLE_BITS     = erz_pkg::ANGLE_BITS,
  parameter int TRIG_FRAC_BITS = erz_pkg::TRIG_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ANGLE_BITS-1:0]        in_roll_angle,
  input  logic [ANGLE_BITS-1:0]        in_pitch_angle,
  input  logic [ANGLE_BITS-1:0]        in_yaw_angle,
  input  logic signed [COORD_BITS-1:0] in_p0_x,
  input  logic signed [COORD_BITS-1:0] in_p0_y,
  input  logic signed [COORD_BITS-1:0] in_p0_z,
  input  logic signed [COORD_BITS-1:0] in_p1_x,
  input  logic signed [COORD_BITS-1:0] in_p1_y,
  input  logic signed [COORD_BITS-1:0] in_p1_z,
  input  logic signed [COORD_BITS-1:0] in_p2_x,
  input  logic signed [COORD_BITS-1:0] in_p2_y,
  input  logic signed [COORD_BITS-1:0] in_p2_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS:0]   out_r0_x,
  output logic signed [COORD_BITS:0]   out_r0_y,
  output logic signed [COORD_BITS:0]   out_r0_z,
  output logic signed [COORD_BITS:0]   out_r1_x,
  output logic signed [COORD_BITS:0]   out_r1_y,
  output logic signed [COORD_BITS:0]   out_r1_z,
  output logic signed [COORD_BITS:0]   out_r2_x,
  output logic signed [COORD_BITS:0]   out_r2_y,
  output logic signed [COORD_BITS:0]   out_r2_z
);

  localparam int NP  = erz_pkg::POINT_COUNT;
  localparam int LAT = erz_pkg::PIPE_LAT;
  localparam int CD  = erz_pkg::TRIG_LAT + erz_pkg::MAT_LAT;
  localparam int TW  = TRIG_FRAC_BITS + 2;

  logic                         adv;
  logic [LAT-1:0]               vld_r, vld_nxt;
  logic signed [COORD_BITS-1:0] pt   [NP][3];
  logic signed [COORD_BITS-1:0] cd_r [CD][NP][3];
  logic signed [TW-1:0]         ca, sa, cb, sb, cg, sg;
  logic signed [TW-1:0]         mtx [3][3];
  logic signed [COORD_BITS:0]   res [NP][3];

  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  assign vld_nxt = adv ? {vld_r[LAT-2:0], in_valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];

  assign pt[0][0] = in_p0_x;
  assign pt[0][1] = in_p0_y;
  assign pt[0][2] = in_p0_z;
  assign pt[1][0] = in_p1_x;
  assign pt[1][1] = in_p1_y;
  assign pt[1][2] = in_p1_z;
  assign pt[2][0] = in_p2_x;
  assign pt[2][1] = in_p2_y;
  assign pt[2][2] = in_p2_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_r[0] <= pt;
      for (int s = 1; s < CD; s++) begin
        cd_r[s] <= cd_r[s-1];
      end
    end
  end

  erz_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_roll (
    .clk(clk), .en(adv), .angle(in_roll_angle), .cos_o(ca), .sin_o(sa)
  );

  erz_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pitch (
    .clk(clk), .en(adv), .angle(in_pitch_angle), .cos_o(cb), .sin_o(sb)
  );

  erz_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
    .clk(clk), .en(adv), .angle(in_yaw_angle), .cos_o(cg), .sin_o(sg)
  );

  erz_matrix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_matrix (
    .clk(clk), .en(adv),
    .ca(ca), .sa(sa), .cb(cb), .sb(sb), .cg(cg), .sg(sg),
    .m_o(mtx)
  );

  for (genvar p = 0; p < NP; p++) begin : g_lane
    erz_lane #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_lane (
      .clk(clk), .en(adv), .m(mtx), .v(cd_r[CD-1][p]), .r_o(res[p])
    );
  end

  assign out_r0_x = res[0][0];
  assign out_r0_y = res[0][1];
  assign out_r0_z = res[0][2];
  assign out_r1_x = res[1][0];
  assign out_r1_y = res[1][1];
  assign out_r1_z = res[1][2];
  assign out_r2_x = res[2][0];
  assign out_r2_y = res[2][1];
  assign out_r2_z = res[2][2];

`ifndef SYNTHESIS
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (vld_r[0] == $past(in_valid)))
    else $error("pipeline entry valid mismatch");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while held");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

### sv/erz_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erz_cordic
// Pipelined rotation-mode CORDIC: binary angle in, rounded cos/sin out.
// ----------------------------------------------------------------------------
module erz_cordic #(
  parameter int ANGLE_BITS     = erz_pkg::ANGLE_BITS,
  parameter int TRIG_FRAC_BITS = erz_pkg::TRIG_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ANGLE_BITS-1:0]           angle,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int XW = erz_pkg::CORDIC_XW;
  localparam int ZW = erz_pkg::CORDIC_ZW;
  localparam int N  = erz_pkg::CORDIC_STEPS;
  localparam int SH = erz_pkg::CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam int TB = erz_pkg::TURN_BITS;

  localparam logic signed [XW-1:0] RND   = XW'(1) <<< (SH - 1);
  localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< TRIG_FRAC_BITS;
  localparam logic signed [XW-1:0] NEG_X = -ONE_X;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [TB-1:0]          turn;
  logic signed [XW-1:0]   x_r [N+1];
  logic signed [XW-1:0]   y_r [N+1];
  logic signed [ZW-1:0]   z_r [N+1];
  logic [1:0]             q_r [N+1];
  logic signed [XW-1:0]   xs, ys, xc, yc;
  logic signed [TW-1:0]   c_t, s_t, cos_nxt, sin_nxt, cos_r, sin_r;

  assign turn = {angle, {(TB-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= XW'(erz_pkg::CORDIC_GAIN_INV);
      y_r[0] <= '0;
      z_r[0] <= {{(ZW-30){1'b0}}, turn[29:0]};
      q_r[0] <= turn[TB-1:TB-2];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = {{(ZW-30){1'b0}}, erz_pkg::atan_turn(5'(i))};
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  always_comb begin
    xs = (x_r[N] + RND) >>> SH;
    ys = (y_r[N] + RND) >>> SH;
    xc = (xs > ONE_X) ? ONE_X : ((xs < NEG_X) ? NEG_X : xs);
    yc = (ys > ONE_X) ? ONE_X : ((ys < NEG_X) ? NEG_X : ys);
    c_t = TW'(xc);
    s_t = TW'(yc);
    case (q_r[N])
      QUAD_1: begin
        cos_nxt = -s_t;
        sin_nxt = c_t;
      end
      QUAD_2: begin
        cos_nxt = -c_t;
        sin_nxt = -s_t;
      end
      QUAD_3: begin
        cos_nxt = s_t;
        sin_nxt = -c_t;
      end
      QUAD_0: begin
        cos_nxt = c_t;
        sin_nxt = s_t;
      end
      default: begin
        cos_nxt = c_t;
        sin_nxt = s_t;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

### sv/erz_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erz_matrix
// Builds Rz*Ry*Rx from the three cos/sin pairs in three register stages.
// ----------------------------------------------------------------------------
module erz_matrix #(
  parameter int TRIG_FRAC_BITS = erz_pkg::TRIG_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [TRIG_FRAC_BITS+1:0] ca,
  input  logic signed [TRIG_FRAC_BITS+1:0] sa,
  input  logic signed [TRIG_FRAC_BITS+1:0] cb,
  input  logic signed [TRIG_FRAC_BITS+1:0] sb,
  input  logic signed [TRIG_FRAC_BITS+1:0] cg,
  input  logic signed [TRIG_FRAC_BITS+1:0] sg,
  output logic signed [TRIG_FRAC_BITS+1:0] m_o [3][3]
);

  localparam int TF = TRIG_FRAC_BITS;
  localparam int TW = TF + 2;
  localparam int PW = 2 * TW;
  localparam int EW = 3 * TW + 1;

  localparam logic signed [EW-1:0] RND   = EW'(1) <<< (2 * TF - 1);
  localparam logic signed [EW-1:0] ONE_E = EW'(1) <<< TF;
  localparam logic signed [EW-1:0] NEG_E = -ONE_E;

  logic signed [PW-1:0] cgcb_r, cgsb_r, sgca_r, sgsa_r, sgcb_r;
  logic signed [PW-1:0] sgsb_r, cgca_r, cgsa_r, cbsa_r, cbca_r;
  logic signed [TW-1:0] sa_r, ca_r, sb_r;
  logic signed [EW-1:0] w_nxt [9];
  logic signed [EW-1:0] w_r   [9];
  logic signed [TW-1:0] m_nxt [3][3];
  logic signed [TW-1:0] m_r   [3][3];

  function automatic logic signed [TW-1:0] to_entry(input logic signed [EW-1:0] w);
    logic signed [EW-1:0] s;
    logic signed [EW-1:0] c;
    s = (w + RND) >>> (2 * TF);
    c = (s > ONE_E) ? ONE_E : ((s < NEG_E) ? NEG_E : s);
    return TW'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cgcb_r <= PW'(cg) * PW'(cb);
      cgsb_r <= PW'(cg) * PW'(sb);
      sgca_r <= PW'(sg) * PW'(ca);
      sgsa_r <= PW'(sg) * PW'(sa);
      sgcb_r <= PW'(sg) * PW'(cb);
      sgsb_r <= PW'(sg) * PW'(sb);
      cgca_r <= PW'(cg) * PW'(ca);
      cgsa_r <= PW'(cg) * PW'(sa);
      cbsa_r <= PW'(cb) * PW'(sa);
      cbca_r <= PW'(cb) * PW'(ca);
      sa_r   <= sa;
      ca_r   <= ca;
      sb_r   <= sb;
    end
  end

  always_comb begin
    w_nxt[0] = EW'(cgcb_r) <<< TF;
    w_nxt[1] = EW'(cgsb_r) * EW'(sa_r) - (EW'(sgca_r) <<< TF);
    w_nxt[2] = EW'(cgsb_r) * EW'(ca_r) + (EW'(sgsa_r) <<< TF);
    w_nxt[3] = EW'(sgcb_r) <<< TF;
    w_nxt[4] = EW'(sgsb_r) * EW'(sa_r) + (EW'(cgca_r) <<< TF);
    w_nxt[5] = EW'(sgsb_r) * EW'(ca_r) - (EW'(cgsa_r) <<< TF);
    w_nxt[6] = -(EW'(sb_r) <<< (2 * TF));
    w_nxt[7] = EW'(cbsa_r) <<< TF;
    w_nxt[8] = EW'(cbca_r) <<< TF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        w_r[i] <= w_nxt[i];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        m_nxt[r][k] = to_entry(w_r[3 * r + k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
    end
  end

  assign m_o = m_r;

endmodule

### sv/erz_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erz_lane
// One point lane: matrix times vector, rounded and saturated, registered.
// ----------------------------------------------------------------------------
module erz_lane #(
  parameter int COORD_BITS     = erz_pkg::COORD_BITS,
  parameter int TRIG_FRAC_BITS = erz_pkg::TRIG_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [TRIG_FRAC_BITS+1:0] m [3][3],
  input  logic signed [COORD_BITS-1:0]     v [3],
  output logic signed [COORD_BITS:0]       r_o [3]
);

  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int PRW = TW + COORD_BITS;
  localparam int AW  = PRW + 2;

  localparam logic signed [AW-1:0] RND = AW'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] HI  = (AW'(1) <<< COORD_BITS) - AW'(1);
  localparam logic signed [AW-1:0] LO  = -(AW'(1) <<< COORD_BITS);

  logic signed [PRW-1:0]       prod_r [3][3];
  logic signed [COORD_BITS:0]  r_nxt  [3];
  logic signed [COORD_BITS:0]  r_r    [3];
  logic signed [AW-1:0]        acc    [3];
  logic signed [AW-1:0]        sh     [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[r][k] <= PRW'(m[r][k]) * PRW'(v[k]);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r]   = AW'(prod_r[r][0]) + AW'(prod_r[r][1]) + AW'(prod_r[r][2]);
      sh[r]    = (acc[r] + RND) >>> TRIG_FRAC_BITS;
      r_nxt[r] = (COORD_BITS+1)'((sh[r] > HI) ? HI : ((sh[r] < LO) ? LO : sh[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
    end
  end

  assign r_o = r_r;

endmodule
